// ===== rtl/pal_pkg.sv =====
// shared types and codes for the positional array list
`default_nettype none
package pal_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IN_BITS   = OP_W + POS_W + VAL_W;
  localparam int OUT_BITS  = STAT_W + VAL_W + COUNT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast from the top level to every cell, already qualified by the range checks
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic             set;
    logic             get;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/pal_cell.sv =====
// one list slot: holds an entry and shifts with its neighbors on insert and remove
`default_nettype none
module pal_cell #(
  parameter int IDX  = 0,
  parameter bit LAST = 1'b0
) (
  input  wire                       clk,
  input  wire pal_pkg::cell_ctrl_t  ctrl,
  input  wire [pal_pkg::VAL_W-1:0]  left,
  input  wire [pal_pkg::VAL_W-1:0]  right,
  output logic [pal_pkg::VAL_W-1:0] entry,
  output logic [pal_pkg::VAL_W-1:0] rd
);
  import pal_pkg::*;

  // indexes past the position field's range always sit above any position
  localparam bit               BIG  = (IDX > (2 ** POS_W) - 1);
  localparam logic [POS_W-1:0] IDXP = POS_W'(IDX);

  logic             eq;
  logic             gt;
  logic             ge;
  logic [VAL_W-1:0] entry_next;

  assign eq = !BIG && (ctrl.position == IDXP);
  assign gt = BIG || (ctrl.position < IDXP);
  assign ge = gt || eq;

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (gt) begin
        entry_next = left;
      end else if (eq) begin
        entry_next = ctrl.value;
      end
    end else if (ctrl.remove) begin
      if (ge && !LAST) begin
        entry_next = right;
      end
    end else if (ctrl.set && eq) begin
      entry_next = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign rd = (ctrl.get && eq) ? entry : '0;

endmodule
`default_nettype wire

// ===== rtl/positional_array_list.sv =====
// top level: range checks, entry count, row of list cells and result register
//
//  channel  dir  fields (lsb first)
//  s_*      in   op[1:0], position[6:2], value[38:7]
//  m_*      out  status[1:0], read_value[33:2], count[38:34]
//
// one transaction per cycle while s_tready is high; the affected cells shift or load in the cycle it is accepted
// the result appears in the next cycle from a single output register
// s_tready stays high while the output register is empty or being taken, low in reset
// rst clears the count and the output valid; entries stay unknown until written
`default_nettype none
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [pal_pkg::IN_DATA_W-1:0]      s_tdata,  // op, position, value
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [pal_pkg::OUT_DATA_W-1:0]    m_tdata   // status, read_value, count
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  op_t              op;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic             accept;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [W-1:0]     pos_w;
  logic [W-1:0]     cnt_w;
  status_t          status;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] entry   [CAPACITY];
  logic [VAL_W-1:0] rd_part [CAPACITY];
  logic [VAL_W-1:0] rd_or;

  assign op       = op_t'(s_tdata[OP_W-1:0]);
  assign position = s_tdata[OP_W +: POS_W];
  assign value    = s_tdata[OP_W+POS_W +: VAL_W];

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign pos_w = W'(position);
  assign cnt_w = W'(count);

  always_comb begin
    status        = ST_OK;
    count_next    = count;
    ctrl.insert   = 1'b0;
    ctrl.remove   = 1'b0;
    ctrl.set      = 1'b0;
    ctrl.get      = 1'b0;
    ctrl.position = position;
    ctrl.value    = value;
    unique case (op)
      OP_INSERT: begin
        if (count == CAP_C) begin
          status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctrl.insert = accept;
          count_next  = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctrl.remove = accept;
          count_next  = count - 1'b1;
        end
      end
      OP_SET: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctrl.set = accept;
        end
      end
      OP_GET: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctrl.get = accept;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid
      assign left_val = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = entry[i];
    end else begin : g_inner
      assign right_val = entry[i+1];
    end
    pal_cell #(
      .IDX  (i),
      .LAST (i == CAPACITY - 1)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_val),
      .right (right_val),
      .entry (entry[i]),
      .rd    (rd_part[i])
    );
  end

  // at most one cell hits, so an or across the row picks the read
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_part[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {(OUT_DATA_W - OUT_BITS)'(0), COUNT_W'(count_next), rd_or, status};
    end
  end

endmodule
`default_nettype wire

// ===== tb/positional_array_list_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the positional array list: directed table, then random traffic
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int DIR_N       = 29;
  localparam int RANDOM_N    = 1120;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   read_value;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             typed;
    list_result_t     result;
  } dir_row_t;

  localparam list_result_t NO_RESULT = '{ST_OK, 32'd0, 5'd0};

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // op, position, value
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status, read_value, count

  // shadow copy of the list
  logic [VAL_W-1:0] list_vals [CAPACITY];
  int               list_len = 0;
  bit               filling = 1'b1;
  int               burst_left = 0;

  list_result_t pending_results [$];
  int           failures = 0;
  int           cycles = 0;
  int           op_seen [4] = '{0, 0, 0, 0};
  int           full_rejects = 0;
  int           range_rejects = 0;
  int           peak_len = 0;

  // rows without a typed result are checked against the shadow list
  dir_row_t dir_rows [DIR_N] = '{
    '{OP_GET,    5'd0,  32'd0,         1'b1, '{ST_RANGE, 32'd0, 5'd0}},
    '{OP_REMOVE, 5'd0,  32'd0,         1'b1, '{ST_RANGE, 32'd0, 5'd0}},
    '{OP_INSERT, 5'd1,  32'd5,         1'b1, '{ST_RANGE, 32'd0, 5'd0}},
    '{OP_INSERT, 5'd0,  32'h7fff_ffff, 1'b1, '{ST_OK, 32'd0, 5'd1}},
    '{OP_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{ST_OK, 32'd0, 5'd2}},
    '{OP_GET,    5'd1,  32'd0,         1'b1, '{ST_OK, 32'h7fff_ffff, 5'd2}},
    '{OP_SET,    5'd2,  32'd9,         1'b1, '{ST_RANGE, 32'd0, 5'd2}},
    '{OP_INSERT, 5'd2,  32'hffff_ffff, 1'b1, '{ST_OK, 32'd0, 5'd3}},
    '{OP_INSERT, 5'd1,  32'h1234_5678, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd3,  32'h0000_0001, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd0,  32'hdead_beef, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd5,  32'h0000_0000, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd2,  32'h5555_5555, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd6,  32'haaaa_aaaa, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd7,  32'h0f0f_0f0f, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd4,  32'hf0f0_f0f0, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd9,  32'h0000_ffff, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd10, 32'hffff_0000, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd0,  32'h0123_4567, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd12, 32'h89ab_cdef, 1'b0, NO_RESULT},
    '{OP_INSERT, 5'd15, 32'h7654_3210, 1'b0, NO_RESULT},
    // full check wins over the position check
    '{OP_INSERT, 5'd0,  32'd1,         1'b1, '{ST_FULL, 32'd0, 5'd16}},
    '{OP_INSERT, 5'd31, 32'd1,         1'b1, '{ST_FULL, 32'd0, 5'd16}},
    '{OP_GET,    5'd16, 32'd0,         1'b1, '{ST_RANGE, 32'd0, 5'd16}},
    '{OP_GET,    5'd15, 32'd0,         1'b0, NO_RESULT},
    '{OP_SET,    5'd15, 32'h5a5a_5a5a, 1'b1, '{ST_OK, 32'd0, 5'd16}},
    '{OP_REMOVE, 5'd0,  32'hffff_ffff, 1'b1, '{ST_OK, 32'd0, 5'd15}},
    '{OP_REMOVE, 5'd14, 32'd0,         1'b1, '{ST_OK, 32'd0, 5'd14}},
    '{OP_GET,    5'd0,  32'd0,         1'b0, NO_RESULT}
  };

  positional_array_list #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // applies one operation to the shadow list and returns what the block should answer
  function automatic list_result_t list_apply(op_t op, logic [POS_W-1:0] position,
                                              logic [VAL_W-1:0] value);
    list_result_t r;
    int p;
    int i;
    p = int'(position);
    r = NO_RESULT;
    case (op)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      OP_SET: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_vals[p] = value;
      end
      default: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_vals[p];
      end
    endcase
    r.count = COUNT_W'(list_len);
    op_seen[op]++;
    if (r.status == ST_FULL) full_rejects++;
    if (r.status == ST_RANGE) range_rejects++;
    if (list_len > peak_len) peak_len = list_len;
    return r;
  endfunction

  task automatic send_item(op_t op, logic [POS_W-1:0] position, logic [VAL_W-1:0] value,
                           logic typed, list_result_t typed_result);
    list_result_t predicted;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({value, position, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = list_apply(op, position, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // bursts of back-to-back transactions separated by random gaps
  task automatic sender_pause();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // mostly legal positions; the list fills and drains so both ends get exercised
  task automatic pick_random_item(output op_t op, output logic [POS_W-1:0] position,
                                  output logic [VAL_W-1:0] value);
    int unsigned roll;
    if (list_len == CAPACITY) filling = 1'b0;
    else if (list_len == 0) filling = 1'b1;
    else if ($urandom_range(49) == 0) filling = !filling;
    roll = $urandom_range(99);
    if (roll < 45) op = filling ? OP_INSERT : OP_REMOVE;
    else if (roll < 60) op = filling ? OP_REMOVE : OP_INSERT;
    else if (roll < 80) op = OP_SET;
    else op = OP_GET;
    if ($urandom_range(9) == 0 || (op != OP_INSERT && list_len == 0))
      position = POS_W'($urandom_range(31));
    else if (op == OP_INSERT)
      position = POS_W'($urandom_range(list_len));
    else
      position = POS_W'($urandom_range(list_len - 1));
    case ($urandom_range(7))
      0: value = 32'h8000_0000;
      1: value = 32'h7fff_ffff;
      2: value = $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: value = $urandom;
    endcase
  endtask

  // receiver stalls on its own schedule
  initial begin
    int mode;
    int len;
    bit toggle;
    toggle = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(3);
      len = $urandom_range(4, 30);
      repeat (len) begin
        toggle = !toggle;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(1));
          2: m_tready <= ($urandom_range(3) == 0);
          default: m_tready <= toggle;
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic report_mismatch(string field, longint want, longint got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = status_t'(m_tdata[1:0]);
      got.read_value = m_tdata[33:2];
      got.count      = m_tdata[38:34];
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected, actual status %0d count %0d",
                   $time, got.status, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", want.status, got.status);
        if (got.read_value != want.read_value)
          report_mismatch("read_value", $signed(want.read_value), $signed(got.read_value));
        if (got.count != want.count)
          report_mismatch("count", want.count, got.count);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    op_t              op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].position, dir_rows[i].value,
                dir_rows[i].typed, dir_rows[i].result);
      sender_pause();
    end

    repeat (RANDOM_N) begin
      pick_random_item(op, position, value);
      send_item(op, position, value, 1'b0, NO_RESULT);
      sender_pause();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transactions: %0d insert, %0d remove, %0d set, %0d get",
             DIR_N + RANDOM_N, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_SET],
             op_seen[OP_GET]);
    $display("rejected %0d on a full list and %0d out of range; list length peaked at %0d",
             full_rejects, range_rejects, peak_len);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/positional_array_list.sv
tb/positional_array_list_tb.sv
